/* sv/sbm_pkg.sv */
// Shared constants and types of the spectrum bar meter.
`timescale 1ns / 1ps
package sbm_pkg;

  localparam int unsigned IDX_W      = 6;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned LVL_W      = 17;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned FREQ_W     = 15;
  localparam int unsigned LG_W       = 21;   // log2 result, Q5.16
  localparam int unsigned LG_STAGES  = 16;   // one squaring per fraction bit
  localparam int unsigned DIV_W      = 28;
  localparam int unsigned DIV_STEP   = 4;    // quotient bits per divider stage
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEP;
  localparam int unsigned NBARS      = 64;

  localparam logic [LVL_W-1:0] LEVEL_FULL = 17'd65536;

  typedef enum logic [1:0] {
    REG_BAR_COUNT = 2'd0,
    REG_LOG_AXIS  = 2'd1,
    REG_FREQ_LOW  = 2'd2,
    REG_FREQ_HIGH = 2'd3
  } sbm_reg_e;

  // Control that travels beside the data through every stage.
  typedef struct packed {
    logic             vld;
    logic             active;  // bar below bar_count, store gets updated
    logic             zero;    // zero magnitude
    logic [IDX_W-1:0] idx;
  } sbm_side_t;

  // Carried around the divider.
  typedef struct packed {
    sbm_side_t          side;
    logic [LG_W-1:0]    lgm;   // log2 of the magnitude
    logic signed [LG_W:0] oct; // log2 difference of the edge terms
    logic               neg;
  } sbm_mid_t;

endpackage

/* sv/sbm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbm_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/sbm_log2.sv */
// Pipelined log2 in Q16: normalize, then one squaring stage per fraction bit.
`timescale 1ns / 1ps
module sbm_log2 import sbm_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] x_i,
  output logic [LG_W-1:0]  lg_o
);

  logic [30:0]          m_q [LG_STAGES+1];
  logic [4:0]           p_q [LG_STAGES+1];
  logic [LG_STAGES-1:0] f_q [LG_STAGES+1];

  logic [4:0]  pos;
  logic [61:0] norm;
  logic [30:0] m0;
  logic [61:0] sq [1:LG_STAGES];

  always_comb begin
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (x_i[i]) pos = 5'(i);
    end
    norm = {x_i, 30'b0} >> pos;
    m0   = (x_i == '0) ? 31'h4000_0000 : norm[30:0];
  end

  always_comb begin
    for (int i = 1; i <= LG_STAGES; i++) begin
      sq[i] = 62'(m_q[i-1]) * 62'(m_q[i-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m0;
      p_q[0] <= pos;
      f_q[0] <= '0;
      for (int i = 1; i <= LG_STAGES; i++) begin
        p_q[i] <= p_q[i-1];
        if (sq[i][61]) begin
          m_q[i] <= sq[i][61:31];
          f_q[i] <= {f_q[i-1][LG_STAGES-2:0], 1'b1};
        end else begin
          m_q[i] <= sq[i][60:30];
          f_q[i] <= {f_q[i-1][LG_STAGES-2:0], 1'b0};
        end
      end
    end
  end

  assign lg_o = {p_q[LG_STAGES], f_q[LG_STAGES]};

endmodule

/* sv/sbm_div.sv */
// Pipelined restoring divider, a few quotient bits per stage.
`timescale 1ns / 1ps
module sbm_div import sbm_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] dvd_i,
  input  logic [CNT_W-1:0] dvs_i,
  output logic [DIV_W-1:0] quo_o
);

  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [DIV_W-1:0] dvd;
    logic [DIV_W-1:0] quo;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s, logic [CNT_W-1:0] d);
    div_st_t    r;
    logic [CNT_W:0] t;
    r = s;
    for (int b = 0; b < DIV_STEP; b++) begin
      t     = {r.rem, r.dvd[DIV_W-1]};
      r.dvd = r.dvd << 1;
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.quo = {r.quo[DIV_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[DIV_W-2:0], 1'b0};
      end
      r.rem = t[CNT_W-1:0];
    end
    return r;
  endfunction

  div_st_t st_q [DIV_STAGES];
  div_st_t st0;

  assign st0 = '{rem: '0, dvd: dvd_i, quo: '0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(st0, dvs_i);
      for (int j = 1; j < DIV_STAGES; j++) begin
        st_q[j] <= div_step(st_q[j-1], dvs_i);
      end
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;

endmodule

/* sv/spectrum_bar_meter_core.sv */
// Spectrum bar meter: tilted dB level of one bar, peak-rise / slow-fall smoothing.
//
//  channel  dir  handshake                   payload (low bit up)
//  s_axis   in   s_axis_tvalid/tready        bar_index[5:0], band_magnitude[37:6]
//  m_axis   out  m_axis_tvalid/tready        bar_number[5:0], bar_level[22:6]
//  cfg      in   cfg_we_i                    cfg_addr_i = register, cfg_wdata_i
//
// One beat per cycle sustained while the skid entry is empty and s_axis_tready is high.
// The pipe depth is set by the three 17-stage log2 squaring pipes and the 7-stage
// divider for the log-axis tilt. Async active-low reset clears the per-bar
// valid bits, so every bar level reads zero right after reset.
// Back pressure: an output register plus one skid entry; s_axis_tready drops
// only while the skid entry is full, and the whole pipe then holds.
`timescale 1ns / 1ps
module spectrum_bar_meter_core import sbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_addr_i,
  input  logic [FREQ_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,   // bar_index, band_magnitude, pad
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata    // bar_number, bar_level, pad
);

  localparam logic signed [42:0] K_DB    = 43'sd394566;      // 20*log10(2), Q16
  localparam logic signed [22:0] MAG_OFS = 23'sd1572864;     // 24.0 in Q16
  localparam logic signed [48:0] DB_OFS  = 49'sd257698037760; // 60 dB in Q32
  localparam logic [30:0]        SAT_X   = 31'd983040;       // 15 * 65536
  localparam logic [24:0]        RECIP15 = 25'd17895698;     // ceil(2^28/15)
  localparam logic [17:0]        RECIP10 = 18'd104858;       // ceil(2^20/10)

  // ---------------- configuration registers ----------------
  logic [CNT_W-1:0]  bar_count_q;
  logic              log_axis_q;
  logic [FREQ_W-1:0] flo_q, fhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_count_q <= 7'd64;
      log_axis_q  <= 1'b1;
      flo_q       <= 15'd20;
      fhi_q       <= 15'd20000;
    end else if (cfg_we_i) begin
      unique case (sbm_reg_e'(cfg_addr_i))
        REG_BAR_COUNT: bar_count_q <= cfg_wdata_i[CNT_W-1:0];
        REG_LOG_AXIS:  log_axis_q  <= cfg_wdata_i[0];
        REG_FREQ_LOW:  flo_q       <= cfg_wdata_i;
        REG_FREQ_HIGH: fhi_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero frequency counts as 1 Hz
  logic [FREQ_W-1:0] flo_e, fhi_e;
  assign flo_e = (flo_q == '0) ? 15'd1 : flo_q;
  assign fhi_e = (fhi_q == '0) ? 15'd1 : fhi_q;

  // ---------------- pipe enable and accept ----------------
  logic en, accept;
  logic skid_vld_q, out_vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  logic [IDX_W-1:0] in_idx;
  logic [MAG_W-1:0] in_mag;
  logic [CNT_W-1:0] in_k;
  assign in_idx = s_axis_tdata[5:0];
  assign in_mag = s_axis_tdata[37:6];
  assign in_k   = CNT_W'(in_idx) + 7'd1;

  // ---------------- stage A: input capture, edge products ----------------
  sbm_side_t        a_side_q;
  logic [MAG_W-1:0] a_mag_q;
  logic [21:0]      a_pa_q, a_pb_q, a_pn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q <= '0;
    end else if (en) begin
      a_side_q.vld    <= accept;
      a_side_q.active <= (CNT_W'(in_idx) < bar_count_q);
      a_side_q.zero   <= (in_mag == '0);
      a_side_q.idx    <= in_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mag_q <= in_mag;
      a_pa_q  <= 22'(flo_e) * 22'(bar_count_q - in_k);
      a_pb_q  <= 22'(fhi_e) * 22'(in_k);
      a_pn_q  <= 22'(flo_e) * 22'(bar_count_q);
    end
  end

  // ---------------- log2 pipes ----------------
  logic [MAG_W-1:0] lgx_a, lgx_b;
  logic [LG_W-1:0]  lg_m, lg_a, lg_b;

  // log axis: lg(fhi) - lg(flo); linear axis: lg(f edge sum) - lg(flo * N)
  assign lgx_a = log_axis_q ? MAG_W'(fhi_e) : MAG_W'(23'(a_pa_q) + 23'(a_pb_q));
  assign lgx_b = log_axis_q ? MAG_W'(flo_e) : MAG_W'(a_pn_q);

  sbm_log2 u_lg_mag (.clk_i, .en_i(en), .x_i(a_mag_q), .lg_o(lg_m));
  sbm_log2 u_lg_a   (.clk_i, .en_i(en), .x_i(lgx_a),   .lg_o(lg_a));
  sbm_log2 u_lg_b   (.clk_i, .en_i(en), .x_i(lgx_b),   .lg_o(lg_b));

  sbm_side_t lg_side_q [LG_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LG_STAGES; i++) lg_side_q[i] <= '0;
    end else if (en) begin
      lg_side_q[0] <= a_side_q;
      for (int i = 1; i <= LG_STAGES; i++) lg_side_q[i] <= lg_side_q[i-1];
    end
  end

  // ---------------- stage D: octave difference ----------------
  sbm_mid_t           d_mid_q;
  logic signed [LG_W:0] oct_d;

  assign oct_d = $signed({1'b0, lg_a}) - $signed({1'b0, lg_b});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_mid_q <= '0;
    end else if (en) begin
      d_mid_q.side <= lg_side_q[LG_STAGES];
      d_mid_q.lgm  <= lg_m;
      d_mid_q.oct  <= oct_d;
      d_mid_q.neg  <= oct_d[LG_W];
    end
  end

  // log axis tilt = oct * (idx+1) / N, truncated toward zero: divide magnitudes
  logic [LG_W:0]      oct_abs;
  logic [DIV_W-1:0]   dvd;
  logic [DIV_W-1:0]   quo;
  assign oct_abs = d_mid_q.neg ? (LG_W+1)'(-d_mid_q.oct) : d_mid_q.oct;
  assign dvd     = DIV_W'(oct_abs) * DIV_W'(CNT_W'(d_mid_q.side.idx) + 7'd1);

  sbm_div u_div (.clk_i, .en_i(en), .dvd_i(dvd), .dvs_i(bar_count_q), .quo_o(quo));

  sbm_mid_t dv_q [DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DIV_STAGES; j++) dv_q[j] <= '0;
    end else if (en) begin
      dv_q[0] <= d_mid_q;
      for (int j = 1; j < DIV_STAGES; j++) dv_q[j] <= dv_q[j-1];
    end
  end

  // ---------------- stage M1: dB and tilt products ----------------
  sbm_mid_t            mid;
  logic signed [28:0]  tq, tqq;
  logic signed [22:0]  lgm_c;
  sbm_side_t           m1_side_q;
  logic signed [42:0]  m1_p_q;
  logic signed [32:0]  m1_t_q;

  assign mid   = dv_q[DIV_STAGES-1];
  assign tqq   = $signed({1'b0, quo});
  assign tq    = log_axis_q ? (mid.neg ? -tqq : tqq) : 29'(mid.oct);
  assign lgm_c = $signed({2'b00, mid.lgm}) - MAG_OFS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1_side_q <= '0;
    else if (en) m1_side_q <= mid.side;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_p_q <= K_DB * 43'(lgm_c);
      m1_t_q <= (33'(tq) <<< 3) + 33'(tq);   // 4.5 dB/oct = 9 << 15 in Q32
    end
  end

  // ---------------- stage M2: sum, range check ----------------
  logic signed [48:0] num;
  logic               num_pos;
  sbm_side_t          m2_side_q;
  logic               m2_zero_q, m2_sat_q;
  logic [19:0]        m2_x_q;

  assign num     = DB_OFS + 49'(m1_p_q) + (49'(m1_t_q) <<< 15);
  assign num_pos = (num > 49'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2_side_q <= '0;
    else if (en) m2_side_q <= m1_side_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_zero_q <= m1_side_q.zero || !num_pos;
      m2_sat_q  <= (num[48:18] >= SAT_X);
      m2_x_q    <= num[37:18];
    end
  end

  // ---------------- stage M3: divide by 15 by reciprocal ----------------
  logic [44:0]      prod15;
  sbm_side_t        m3_side_q;
  logic [LVL_W-1:0] m3_t_q;

  assign prod15 = 45'(m2_x_q) * 45'(RECIP15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m3_side_q <= '0;
    else if (en) m3_side_q <= m2_side_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (m2_zero_q)     m3_t_q <= '0;
      else if (m2_sat_q) m3_t_q <= LEVEL_FULL;
      else               m3_t_q <= {1'b0, prod15[43:28]};
    end
  end

  // ---------------- stage U: level store read-modify-write ----------------
  sbm_side_t        u_side_q;
  logic [LVL_W-1:0] u_t_q;
  logic [LVL_W-1:0] ram_rd;
  logic [NBARS-1:0] lvl_vld_q;
  logic             rd_vld_q;
  logic             wr_vld_q;
  logic [IDX_W-1:0] wr_idx_q;
  logic [LVL_W-1:0] wr_lvl_q;
  logic             ram_we;

  logic [LVL_W-1:0] stored, fall, upd, res_lvl;
  logic [17:0]      diff5;
  logic [35:0]      prod10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) u_side_q <= '0;
    else if (en) u_side_q <= m3_side_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) u_t_q <= m3_t_q;
  end

  sbm_ram #(.WIDTH(LVL_W), .DEPTH(NBARS)) u_lvl_ram (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(u_side_q.idx),
    .wdata_i(upd),
    .re_i   (en),
    .raddr_i(m3_side_q.idx),
    .rdata_o(ram_rd)
  );

  // per-bar valid bits stand in for clearing the store; last write bypasses
  // the read issued in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
    end else begin
      if (en) rd_vld_q <= lvl_vld_q[m3_side_q.idx];
      if (ram_we) begin
        lvl_vld_q[u_side_q.idx] <= 1'b1;
        wr_vld_q                <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wr_idx_q <= u_side_q.idx;
      wr_lvl_q <= upd;
    end
  end

  always_comb begin
    if (wr_vld_q && (wr_idx_q == u_side_q.idx)) stored = wr_lvl_q;
    else if (rd_vld_q)                          stored = ram_rd;
    else                                        stored = '0;
    // fall by (stored - target + 5) / 10
    diff5  = 18'(stored) - 18'(u_t_q) + 18'd5;
    prod10 = 36'(diff5) * 36'(RECIP10);
    fall   = stored - LVL_W'(prod10[34:20]);
    upd    = (u_t_q > stored) ? u_t_q : fall;
    res_lvl = u_side_q.active ? upd : stored;
  end

  assign ram_we = en && u_side_q.vld && u_side_q.active;

  // ---------------- output register and skid entry ----------------
  logic [IDX_W-1:0] out_idx_q, skid_idx_q;
  logic [LVL_W-1:0] out_lvl_q, skid_lvl_q;
  logic             out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= u_side_q.vld;
    end else if (u_side_q.vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_idx_q <= skid_idx_q;
        out_lvl_q <= skid_lvl_q;
      end
    end else if (out_free) begin
      out_idx_q <= u_side_q.idx;
      out_lvl_q <= res_lvl;
    end else begin
      skid_idx_q <= u_side_q.idx;
      skid_lvl_q <= res_lvl;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_lvl_q, out_idx_q};

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry filled while output register empty");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q)
    else $error("pending result dropped");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (upd <= LEVEL_FULL))
    else $error("bar level above full scale");

endmodule
